// File: design/ipv6_icmpv6_receive_checker_core_macros.svh
// ----------------------------------------------------------------------------
// IPv6 ICMPv6 receive checker assertion macros
// Clocked assertions on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IPV6_ICMPV6_RECEIVE_CHECKER_CORE_MACROS_SVH
`define IPV6_ICMPV6_RECEIVE_CHECKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IPV6CK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define IPV6CK_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);
`else
`define IPV6CK_ASSERT(lbl, prop, msg)
`define IPV6CK_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: design/ipv6ck_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 ICMPv6 receive checker package
// Shared types, codes and sizes.
// ----------------------------------------------------------------------------
package ipv6ck_pkg;

    localparam int MAX_PACKET_BYTES = 65575;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int HDR_BYTES        = 40;
    localparam int SUM_START        = 8;
    localparam int ICMP_MIN_BYTES   = 8;
    localparam int QDEPTH           = 4;
    localparam int QAW              = $clog2(QDEPTH);

    localparam logic [3:0] IP_VERSION      = 4'd6;
    localparam logic [7:0] ICMP_PROTO      = 8'd58;
    localparam logic [7:0] ICMP_ECHO_REQ   = 8'd128;
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd129;
    localparam logic [7:0] ND_ROUTER_SOL   = 8'd133;
    localparam logic [7:0] ND_NEIGHBOR_ADV = 8'd136;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_VERSION  = 3'd2,
        ST_BAD_LENGTH   = 3'd3,
        ST_ICMP_SHORT   = 3'd4,
        ST_BAD_CHECKSUM = 3'd5,
        ST_UNKNOWN_TYPE = 3'd6,
        ST_NOT_ICMP     = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  next_proto;
        logic [7:0]  message_type;
        logic        reply_wanted;
        logic [15:0] reply_checksum;
        logic [15:0] payload_bytes;
    } t_result;

    // Per-packet summary handed from the byte front end to the checker
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [31:0]      sum;
        logic [3:0]       version;
        logic [15:0]      plen;
        logic [7:0]       nxt_hdr;
        logic [15:0]      rx_checksum;
        logic [7:0]       icmp_type;
        logic [7:0]       high_hold;
    } t_summary;

endpackage

// File: design/ipv6_icmpv6_receive_checker_core.sv
// ----------------------------------------------------------------------------
// IPv6 ICMPv6 receive checker core
// Throughput: one packet byte per cycle, held only while the summary queue is full.
// The verdict reaches the result side through the summary queue and the 3-stage
// verdict pipeline, which drains one packet per cycle while no unpopped result
// holds it back; the front end's running sum keeps the byte rate. Reset (i_rst_n
// low, synchronous) clears all parse state, empties the summary queue and drops any verdict not yet popped.
// ----------------------------------------------------------------------------
module ipv6_icmpv6_receive_checker_core
    import ipv6ck_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    // A request is taken while the summary queue has room
    logic     byte_take;
    logic     sum_push;
    t_summary sum_in;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_summary q_data;
    logic     res_empty;

    assign full      = q_full;
    assign byte_take = push && !q_full;

    // Front end: parse fields, run the checksum, emit a summary per packet
    ipv6ck_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (byte_take),
        .i_item     (i_item),
        .o_sum_push (sum_push),
        .o_sum      (sum_in)
    );

    // Decouple the byte stream from the verdict pipeline
    ipv6ck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_push),
        .i_data  (sum_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Back end: fold, compare, classify and hold the result for pop
    ipv6ck_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_sum    (q_data),
        .o_take   (q_pop),
        .o_empty  (res_empty),
        .i_pop    (pop && !res_empty),
        .o_result (o_result)
    );

    assign empty = res_empty;

endmodule

// File: design/ipv6ck_front.sv
// ----------------------------------------------------------------------------
// IPv6 ICMPv6 receive checker byte front end
// Parses header fields and keeps the running checksum, one byte per cycle while i_take is high.
// ----------------------------------------------------------------------------
`include "ipv6_icmpv6_receive_checker_core_macros.svh"

module ipv6ck_front
    import ipv6ck_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_item i_item,
    output logic     o_sum_push,
    output t_summary o_sum
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_sum, n_sum;
    logic [3:0]       r_version, n_version;
    logic [15:0]      r_plen, n_plen;
    logic [7:0]       r_nh, n_nh;
    logic [15:0]      r_rxck, n_rxck;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_hold, n_hold;

    logic             room;
    logic [CNT_W-1:0] pay_idx;
    logic             in_hdr;
    logic             in_pay;
    logic             ck_field;
    logic [7:0]       val;
    logic [7:0]       b;

    assign b       = i_item.data_byte;
    assign room    = r_count < CNT_W'(MAX_PACKET_BYTES);
    assign pay_idx = r_count - CNT_W'(HDR_BYTES);
    assign in_hdr  = (r_count >= CNT_W'(SUM_START)) && (r_count < CNT_W'(HDR_BYTES));
    assign in_pay  = (r_count >= CNT_W'(HDR_BYTES)) && (17'(pay_idx) < 17'(r_plen));
    assign ck_field = in_pay && ((pay_idx == CNT_W'(2)) || (pay_idx == CNT_W'(3)));
    assign val     = ck_field ? 8'h00 : b;

    always_comb begin
        n_count   = r_count;
        n_sum     = r_sum;
        n_version = r_version;
        n_plen    = r_plen;
        n_nh      = r_nh;
        n_rxck    = r_rxck;
        n_type    = r_type;
        n_hold    = r_hold;
        if (i_take && room) begin
            n_count = r_count + CNT_W'(1);
            if (r_count == CNT_W'(0)) begin
                n_version = b[7:4];
            end
            if (r_count == CNT_W'(4)) begin
                n_plen[15:8] = b;
            end
            if (r_count == CNT_W'(5)) begin
                n_plen[7:0] = b;
            end
            if (r_count == CNT_W'(6)) begin
                n_nh = b;
            end
            if (in_pay && pay_idx == CNT_W'(0)) begin
                n_type = b;
            end
            if (in_pay && pay_idx == CNT_W'(2)) begin
                n_rxck[15:8] = b;
            end
            if (in_pay && pay_idx == CNT_W'(3)) begin
                n_rxck[7:0] = b;
            end
            if (in_hdr || in_pay) begin
                if (!r_count[0]) begin
                    n_hold = val;
                end else begin
                    n_sum = r_sum + {16'h0000, r_hold, val};
                end
            end
        end
    end

    always_comb begin
        o_sum.byte_count  = n_count;
        o_sum.sum         = n_sum;
        o_sum.version     = n_version;
        o_sum.plen        = n_plen;
        o_sum.nxt_hdr     = n_nh;
        o_sum.rx_checksum = n_rxck;
        o_sum.icmp_type   = n_type;
        o_sum.high_hold   = n_hold;
    end

    assign o_sum_push = i_take && i_item.last_byte;

    // Clear everything after the final byte of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_sum_push) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_version <= '0;
            r_plen    <= '0;
            r_nh      <= '0;
            r_rxck    <= '0;
            r_type    <= '0;
            r_hold    <= '0;
        end else begin
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_version <= n_version;
            r_plen    <= n_plen;
            r_nh      <= n_nh;
            r_rxck    <= n_rxck;
            r_type    <= n_type;
            r_hold    <= n_hold;
        end
    end

    `IPV6CK_ASSERT(a_count_bound, r_count <= CNT_W'(MAX_PACKET_BYTES), "byte count past limit")
    `IPV6CK_ASSERT_NEXT(a_clear_after_last, o_sum_push, r_count == '0 && r_sum == '0, "state not cleared")

endmodule

// File: design/ipv6ck_queue.sv
// ----------------------------------------------------------------------------
// IPv6 ICMPv6 receive checker summary queue
// Short register queue between the byte front end and the checker.
// ----------------------------------------------------------------------------
`include "ipv6_icmpv6_receive_checker_core_macros.svh"

module ipv6ck_queue
    import ipv6ck_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_summary o_data
);

    t_summary         r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_count;

    assign o_full  = r_count == (QAW+1)'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

    `IPV6CK_ASSERT(a_q_bound, r_count <= (QAW+1)'(QDEPTH), "queue count past depth")
    `IPV6CK_ASSERT_NEXT(a_q_fill, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count")

endmodule

// File: design/ipv6ck_back.sv
// ----------------------------------------------------------------------------
// IPv6 ICMPv6 receive checker verdict pipeline
// Finishes the checksum, classifies the packet and holds the result.
// ----------------------------------------------------------------------------
`include "ipv6_icmpv6_receive_checker_core_macros.svh"

module ipv6ck_back
    import ipv6ck_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_summary i_sum,
    output logic     o_take,
    output logic     o_empty,
    input  logic     i_pop,
    output t_result  o_result
);

    // stage 1: full sum and header checks
    logic        r_v1;
    logic [31:0] r1_sum;
    logic        r1_fail;
    t_status     r1_status;
    logic [7:0]  r1_nh, r1_type;
    logic [15:0] r1_plen, r1_rxck;

    // stage 2: folded sum and compare
    logic        r_v2;
    logic [15:0] r2_fold;
    logic        r2_ck_ok;
    logic        r2_fail;
    t_status     r2_status;
    logic [7:0]  r2_nh, r2_type;
    logic [15:0] r2_plen;

    // stage 3: result register
    logic        r_v3;
    t_result     r_out;

    logic        rdy1, rdy2, rdy3;

    logic [31:0] n1_sum;
    logic [31:0] pad;
    logic        n1_fail;
    t_status     n1_status;
    logic [16:0] fold_a;
    logic [15:0] fold_b;
    logic [16:0] rep_a;
    logic [15:0] rep_b;
    t_result     n_out;

    assign rdy3   = !r_v3 || i_pop;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign o_take = i_valid && rdy1;

    assign pad    = i_sum.plen[0] ? {16'h0000, i_sum.high_hold, 8'h00} : 32'h0;
    assign n1_sum = i_sum.sum + {16'h0000, i_sum.plen} + {24'h0, ICMP_PROTO} + pad;

    // Header checks in priority order; checksum and type come later
    always_comb begin
        n1_fail   = 1'b1;
        n1_status = ST_OK;
        if (i_sum.byte_count < CNT_W'(HDR_BYTES)) begin
            n1_status = ST_SHORT;
        end else if (i_sum.version != IP_VERSION) begin
            n1_status = ST_BAD_VERSION;
        end else if (18'(i_sum.byte_count) < 18'(HDR_BYTES) + 18'(i_sum.plen)) begin
            n1_status = ST_BAD_LENGTH;
        end else if (i_sum.nxt_hdr != ICMP_PROTO) begin
            n1_status = ST_NOT_ICMP;
        end else if (i_sum.plen < 16'(ICMP_MIN_BYTES)) begin
            n1_status = ST_ICMP_SHORT;
        end else begin
            n1_fail = 1'b0;
        end
    end

    assign fold_a = {1'b0, r1_sum[15:0]} + {1'b0, r1_sum[31:16]};
    assign fold_b = fold_a[15:0] + {15'h0, fold_a[16]};

    // Echo reply raises the type byte by one: add 0x0100 to the folded sum
    assign rep_a = {1'b0, r2_fold} + 17'h00100;
    assign rep_b = rep_a[15:0] + {15'h0, rep_a[16]};

    always_comb begin
        n_out.status         = r2_status;
        n_out.next_proto     = r2_nh;
        n_out.message_type   = r2_type;
        n_out.reply_wanted   = 1'b0;
        n_out.reply_checksum = 16'h0000;
        n_out.payload_bytes  = r2_plen;
        if (!r2_fail) begin
            if (!r2_ck_ok) begin
                n_out.status = ST_BAD_CHECKSUM;
            end else if (r2_type == ICMP_ECHO_REQ) begin
                n_out.status         = ST_OK;
                n_out.reply_wanted   = 1'b1;
                n_out.reply_checksum = ~rep_b;
            end else if (r2_type inside {ICMP_ECHO_REPLY, [ND_ROUTER_SOL:ND_NEIGHBOR_ADV]}) begin
                n_out.status = ST_OK;
            end else begin
                n_out.status = ST_UNKNOWN_TYPE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_sum    <= n1_sum;
            r1_fail   <= n1_fail;
            r1_status <= n1_status;
            r1_nh     <= i_sum.nxt_hdr;
            r1_type   <= i_sum.icmp_type;
            r1_plen   <= i_sum.plen;
            r1_rxck   <= i_sum.rx_checksum;
        end
        if (rdy2) begin
            r2_fold   <= fold_b;
            r2_ck_ok  <= (~fold_b) == r1_rxck;
            r2_fail   <= r1_fail;
            r2_status <= r1_status;
            r2_nh     <= r1_nh;
            r2_type   <= r1_type;
            r2_plen   <= r1_plen;
        end
        if (rdy3) begin
            r_out <= n_out;
        end
    end

    assign o_empty  = !r_v3;
    assign o_result = r_out;

    `IPV6CK_ASSERT(a_reply_ok, !r_v3 || !r_out.reply_wanted || r_out.status == ST_OK, "reply on bad packet")
    `IPV6CK_ASSERT(a_reply_zero, !r_v3 || r_out.reply_wanted || r_out.reply_checksum == 16'h0000, "stray reply sum")

endmodule

// File: tb/sv/ipv6_icmpv6_receive_checker_core_test.sv
// ----------------------------------------------------------------------------
// IPv6 ICMPv6 receive checker core testbench
// Streams IPv6 packets into the core one byte per request and checks every
// verdict, field by field, against a byte-level predictor of the header
// checks and the ICMPv6 checksum. A directed table covers each error code and
// the length extremes; a long result-side hold then fills the core, and random
// well-formed and broken packets follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module ipv6_icmpv6_receive_checker_core_test;
    import ipv6ck_pkg::*;

    // ND types the package does not name
    localparam logic [7:0] ND_ROUTER_ADV   = 8'd134;
    localparam logic [7:0] ND_NEIGHBOR_SOL = 8'd135;
    localparam logic [7:0] NH_TCP          = 8'd6;
    localparam int         CYCLE_LIMIT     = 1000000;
    localparam int         RANDOM_BYTES    = 500;
    localparam int         RANDOM_VERDICTS = 6;

    // One directed packet: header fields, wire length (0 = header plus payload)
    // and, where it is obvious, the status the core must report.
    typedef struct {
        int      ver;
        int      plen;
        int      nh;
        int      mtype;
        int      total;
        bit      bad_cs;
        bit      typed;
        t_status status;
    } t_pkt_row;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     pop     = 1'b0;
    t_in_item i_item  = '0;
    logic     full;
    logic     empty;
    t_result  o_result;

    ipv6_icmpv6_receive_checker_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // Predictor state: one packet in flight, cleared on every final byte
    logic [16:0] seen_bytes  = '0;
    logic [31:0] csum_acc    = '0;
    logic [3:0]  hdr_version = '0;
    logic [15:0] hdr_plen    = '0;
    logic [7:0]  hdr_next    = '0;
    logic [15:0] icmp_rx_cs  = '0;
    logic [7:0]  icmp_type   = '0;
    logic [7:0]  odd_hold    = '0;

    t_result    pending_verdicts[$];
    logic [7:0] wire_bytes[$];
    int         bytes_sent      = 0;
    int         verdicts_due    = 0;
    int         mismatch_count  = 0;
    int         send_gap_max    = 10;
    int         recv_gap_max    = 10;
    int         stall_cycles    = 0;
    int         cycle_count     = 0;

    t_pkt_row directed_rows [0:19] = '{
        '{6, 0, ICMP_PROTO, 0, 1, 0, 1, ST_SHORT},                    // lone byte
        '{6, 8, ICMP_PROTO, ICMP_ECHO_REQ, 39, 0, 1, ST_SHORT},       // one short of a header
        '{4, 8, ICMP_PROTO, ICMP_ECHO_REQ, 0, 0, 1, ST_BAD_VERSION},
        '{15, 8, 255, ICMP_ECHO_REQ, 0, 0, 1, ST_BAD_VERSION},
        '{6, 65535, ICMP_PROTO, ICMP_ECHO_REQ, 48, 0, 1, ST_BAD_LENGTH},
        '{6, 8, ICMP_PROTO, ICMP_ECHO_REQ, 47, 0, 1, ST_BAD_LENGTH},
        '{6, 8, NH_TCP, ICMP_ECHO_REQ, 0, 0, 1, ST_NOT_ICMP},
        '{6, 0, ICMP_PROTO, 0, 0, 0, 1, ST_ICMP_SHORT},               // bare header
        '{6, 7, ICMP_PROTO, ICMP_ECHO_REQ, 0, 0, 1, ST_ICMP_SHORT},
        '{6, 8, ICMP_PROTO, ICMP_ECHO_REQ, 0, 1, 1, ST_BAD_CHECKSUM},
        '{6, 8, ICMP_PROTO, 0, 0, 0, 1, ST_UNKNOWN_TYPE},
        '{6, 8, ICMP_PROTO, 255, 0, 0, 1, ST_UNKNOWN_TYPE},
        '{6, 8, ICMP_PROTO, ICMP_ECHO_REQ, 0, 0, 0, ST_OK},
        '{6, 9, ICMP_PROTO, ICMP_ECHO_REQ, 0, 0, 0, ST_OK},           // odd payload
        '{6, 16, ICMP_PROTO, ICMP_ECHO_REPLY, 0, 0, 0, ST_OK},
        '{6, 8, ICMP_PROTO, ND_ROUTER_SOL, 0, 0, 0, ST_OK},
        '{6, 10, ICMP_PROTO, ND_ROUTER_ADV, 0, 0, 0, ST_OK},
        '{6, 12, ICMP_PROTO, ND_NEIGHBOR_SOL, 0, 0, 0, ST_OK},
        '{6, 11, ICMP_PROTO, ND_NEIGHBOR_ADV, 0, 0, 0, ST_OK},
        '{6, 12, ICMP_PROTO, ICMP_ECHO_REQ, 57, 0, 0, ST_OK}          // trailing bytes
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run with a failure once the cycle limit is reached
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Fold carries back in and invert: the Internet checksum of a running sum
    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        while (s[31:16] != 16'h0)
            s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        return ~s[15:0];
    endfunction

    // Advance the predictor by one byte; return 1 with the verdict on a final byte
    function automatic bit predict_verdict(input t_in_item it, output t_result r);
        int          idx;
        int          pidx;
        bit          summed;
        logic [7:0]  v;
        logic [31:0] s;
        t_status     st;
        bit          want;
        logic [15:0] rcs;

        r = '0;
        if (seen_bytes < MAX_PACKET_BYTES) begin
            idx    = int'(seen_bytes);
            v      = it.data_byte;
            summed = 1'b0;
            case (idx)
                0: hdr_version = it.data_byte[7:4];
                4: hdr_plen[15:8] = it.data_byte;
                5: hdr_plen[7:0] = it.data_byte;
                6: hdr_next = it.data_byte;
                default: ;
            endcase
            // Sum the addresses, then the payload up to the length field
            if (idx >= SUM_START && idx < HDR_BYTES) begin
                summed = 1'b1;
            end else if (idx >= HDR_BYTES && idx - HDR_BYTES < int'(hdr_plen)) begin
                pidx   = idx - HDR_BYTES;
                summed = 1'b1;
                if (pidx == 0) begin
                    icmp_type = it.data_byte;
                end else if (pidx == 2) begin
                    icmp_rx_cs[15:8] = it.data_byte;
                    v = 8'h00;
                end else if (pidx == 3) begin
                    icmp_rx_cs[7:0] = it.data_byte;
                    v = 8'h00;
                end
            end
            if (summed) begin
                if (idx[0] == 1'b0)
                    odd_hold = v;
                else
                    csum_acc = csum_acc + {16'h0, odd_hold, v};
            end
            seen_bytes = seen_bytes + 1'b1;
        end
        if (!it.last_byte)
            return 1'b0;

        // Close the sum with the pseudo header length and protocol, pad an odd byte
        s = csum_acc + {16'h0, hdr_plen} + {24'h0, ICMP_PROTO};
        if (hdr_plen[0])
            s = s + {16'h0, odd_hold, 8'h00};
        want = 1'b0;
        rcs  = 16'h0;
        st   = ST_OK;
        if (int'(seen_bytes) < HDR_BYTES)
            st = ST_SHORT;
        else if (hdr_version != IP_VERSION)
            st = ST_BAD_VERSION;
        else if (int'(seen_bytes) < HDR_BYTES + int'(hdr_plen))
            st = ST_BAD_LENGTH;
        else if (hdr_next != ICMP_PROTO)
            st = ST_NOT_ICMP;
        else if (int'(hdr_plen) < ICMP_MIN_BYTES)
            st = ST_ICMP_SHORT;
        else if (ones_fold(s) != icmp_rx_cs)
            st = ST_BAD_CHECKSUM;
        else begin
            case (icmp_type)
                ICMP_ECHO_REQ: begin
                    want = 1'b1;
                    // The reply differs only in its type byte: 128 -> 129
                    rcs  = ones_fold(s + 32'h100);
                end
                ICMP_ECHO_REPLY, ND_ROUTER_SOL, ND_ROUTER_ADV,
                ND_NEIGHBOR_SOL, ND_NEIGHBOR_ADV: st = ST_OK;
                default: st = ST_UNKNOWN_TYPE;
            endcase
        end
        r.status         = st;
        r.next_proto     = hdr_next;
        r.message_type   = icmp_type;
        r.reply_wanted   = want;
        r.reply_checksum = rcs;
        r.payload_bytes  = hdr_plen;

        seen_bytes  = '0;
        csum_acc    = '0;
        hdr_version = '0;
        hdr_plen    = '0;
        hdr_next    = '0;
        icmp_rx_cs  = '0;
        icmp_type   = '0;
        odd_hold    = '0;
        return 1'b1;
    endfunction

    // Build a packet with a valid checksum (unless asked to break it), then
    // cut or pad it to the requested wire length.
    task automatic build_packet(input int ver, input int plen, input int nh,
                                input int mtype, input int total, input bit bad_cs);
        int          natural_len;
        int          gen_len;
        int          n;
        int          i;
        logic [31:0] acc;
        logic [15:0] cs;

        natural_len = HDR_BYTES + plen;
        gen_len     = (total > 0 && total < natural_len) ? total : natural_len;
        n           = (gen_len > 44) ? gen_len : 44;
        wire_bytes.delete();
        for (i = 0; i < n; i++)
            wire_bytes.push_back(8'($urandom_range(0, 255)));
        wire_bytes[0] = {4'(ver), wire_bytes[0][3:0]};
        wire_bytes[4] = 8'(plen >> 8);
        wire_bytes[5] = 8'(plen);
        wire_bytes[6] = 8'(nh);
        if (plen > 0)
            wire_bytes[40] = 8'(mtype);
        if (plen >= 4 && natural_len <= n) begin
            wire_bytes[42] = 8'h00;
            wire_bytes[43] = 8'h00;
            acc = 32'(plen) + {24'h0, ICMP_PROTO};
            for (i = SUM_START; i < natural_len; i += 2)
                acc += {16'h0, wire_bytes[i], (i + 1 < natural_len) ? wire_bytes[i + 1] : 8'h00};
            cs = ones_fold(acc);
            if (bad_cs)
                cs ^= 16'($urandom_range(1, 65535));
            wire_bytes[42] = cs[15:8];
            wire_bytes[43] = cs[7:0];
        end
        while (wire_bytes.size() > gen_len)
            void'(wire_bytes.pop_back());
        while (total > 0 && wire_bytes.size() < total)
            wire_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Offer one byte after a random gap; hold it until the core takes it
    task automatic send_byte(input logic [7:0] b, input bit last,
                             input bit typed, input t_status st);
        int       gap;
        t_in_item it;
        t_result  r;

        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.data_byte = b;
        it.last_byte = last;
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full !== 1'b0);
        // Accepted at this edge: predict what it causes
        bytes_sent++;
        if (predict_verdict(it, r)) begin
            if (typed)
                r.status = st;
            pending_verdicts.push_back(r);
            verdicts_due++;
        end
    endtask

    task automatic send_packet(input bit typed, input t_status st);
        int i;
        for (i = 0; i < wire_bytes.size(); i++)
            send_byte(wire_bytes[i], i == wire_bytes.size() - 1, typed, st);
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch %s: expected 0x%0h got 0x%0h (cycle %0d)",
                     what, want, got, cycle_count);
    endtask

    task automatic check_verdict(input t_result got);
        t_result want;
        if (pending_verdicts.size() == 0) begin
            report("verdict with none pending", 32'h0, 32'(got));
        end else begin
            want = pending_verdicts.pop_front();
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
            if (got.next_proto !== want.next_proto)
                report("next_proto", 32'(want.next_proto), 32'(got.next_proto));
            if (got.message_type !== want.message_type)
                report("message_type", 32'(want.message_type), 32'(got.message_type));
            if (got.reply_wanted !== want.reply_wanted)
                report("reply_wanted", 32'(want.reply_wanted), 32'(got.reply_wanted));
            if (got.reply_checksum !== want.reply_checksum)
                report("reply_checksum", 32'(want.reply_checksum), 32'(got.reply_checksum));
            if (got.payload_bytes !== want.payload_bytes)
                report("payload_bytes", 32'(want.payload_bytes), 32'(got.payload_bytes));
        end
    endtask

    // Result side: take verdicts after random gaps, or hold off for a long
    // stretch when the stimulus asks for it.
    initial begin
        int gap;
        int n;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (stall_cycles > 0) begin
                n = stall_cycles;
                stall_cycles = 0;
                pop <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                gap = $urandom_range(0, recv_gap_max);
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            check_verdict(o_result);
        end
    end

    initial begin
        int      i;
        int      k;
        int      plen;
        int      total;
        int      mtype;
        int      start_bytes;
        int      start_verdicts;
        bit      paused;
        t_pkt_row row;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed packets; any packet over 1000 bytes goes back to back
        for (i = 0; i < $size(directed_rows); i++) begin
            row = directed_rows[i];
            build_packet(row.ver, row.plen, row.nh, row.mtype, row.total, row.bad_cs);
            send_gap_max = (wire_bytes.size() > 1000) ? 0 : 10;
            send_packet(row.typed, row.status);
        end

        // Hold the result side while short packets pour in: fill the core and
        // make it stall its input.
        stall_cycles = 300;
        send_gap_max = 0;
        for (i = 0; i < 16; i++) begin
            wire_bytes.delete();
            wire_bytes.push_back(8'($urandom_range(0, 255)));
            send_packet(1'b0, ST_OK);
        end

        // Random packets, mostly well formed with random content
        start_bytes    = bytes_sent;
        start_verdicts = verdicts_due;
        paused         = 1'b0;
        while (bytes_sent - start_bytes < RANDOM_BYTES
               || verdicts_due - start_verdicts < RANDOM_VERDICTS) begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            k = $urandom_range(0, 99);
            plen = $urandom_range(8, 48);
            if (k < 60) begin
                if ($urandom_range(0, 9) == 0)
                    plen = $urandom_range(0, 7);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: mtype = ICMP_ECHO_REQ;
                    4:          mtype = ICMP_ECHO_REPLY;
                    9:          mtype = $urandom_range(0, 255);
                    default:    mtype = ND_ROUTER_SOL + $urandom_range(0, 3);
                endcase
                total = ($urandom_range(0, 3) == 0) ? HDR_BYTES + plen + $urandom_range(1, 4) : 0;
                build_packet(IP_VERSION, plen, ICMP_PROTO, mtype, total,
                             $urandom_range(0, 9) == 0);
            end else if (k < 70) begin
                // Cut short anywhere in the header or payload
                build_packet(IP_VERSION, plen, ICMP_PROTO, ICMP_ECHO_REQ,
                             $urandom_range(1, HDR_BYTES + plen - 1), 1'b0);
            end else if (k < 78) begin
                build_packet($urandom_range(0, 15), plen, ICMP_PROTO, ICMP_ECHO_REQ, 0, 1'b0);
            end else if (k < 86) begin
                build_packet(IP_VERSION, plen, $urandom_range(0, 255), ICMP_ECHO_REQ, 0, 1'b0);
            end else if (k < 94) begin
                // Plain noise
                wire_bytes.delete();
                total = $urandom_range(1, 60);
                for (i = 0; i < total; i++)
                    wire_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                // Any payload length, short wire length
                build_packet(IP_VERSION, $urandom_range(0, 65535), ICMP_PROTO,
                             ICMP_ECHO_REQ, $urandom_range(40, 100), 1'b0);
            end
            send_packet(1'b0, ST_OK);

            // Once early on, drain the core completely before going on
            if (!paused && verdicts_due - start_verdicts >= 3) begin
                paused = 1'b1;
                push <= 1'b0;
                @(posedge i_clk);
                while (pending_verdicts.size() != 0) @(posedge i_clk);
            end
        end

        // Drain, then give the verdict pipeline time to show anything stray
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/ipv6ck_pkg.sv
design/ipv6ck_front.sv
design/ipv6ck_queue.sv
design/ipv6ck_back.sv
design/ipv6_icmpv6_receive_checker_core.sv
tb/sv/ipv6_icmpv6_receive_checker_core_test.sv
